### rtl/tws_pkg.sv
`default_nettype none

package tws_pkg;

   localparam int SYM_W    = 5;
   localparam int LEN_W    = 7;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 3;
   localparam int FIELD_W  = 16;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_NEXT  = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_ADDED    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_COMPLETE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_WRITTEN  = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [SYM_W-1:0]   key_first;
      logic [SYM_W-1:0]   key_second;
      logic [SYM_W-1:0]   key_third;
      logic [FIELD_W-1:0] frequency;
      logic [FIELD_W-1:0] random_fraction;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0]    symbol_a;
      logic [SYM_W-1:0]    symbol_b;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_SUM,
      ST_SCALE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### rtl/tws_mem.sv
`default_nettype none

module tws_mem #(
   parameter int DEPTH = 19683,
   parameter int AW    = 15,
   parameter int FW    = 16
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [FW-1:0] wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [FW-1:0] rdata
);

   logic [FW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

### rtl/tws_alu.sv
`default_nettype none

module tws_alu #(
   parameter int W = 28
) (
   input  wire logic [W-1:0] op_a,
   input  wire logic [W-1:0] op_b,
   input  wire logic [W-1:0] cmp_ref,
   output logic      [W-1:0] sum,
   output logic              gt
);

   // shared adder: totals, scaling steps and running sums all pass here
   assign sum = op_a + op_b;
   assign gt  = (sum > cmp_ref);

endmodule

`default_nettype wire

### rtl/trigram_weighted_char_sampler.sv
`default_nettype none

// Trigram weighted symbol sampler. Holds an ALPHABET^3 table of trigram
// frequencies (symbol 0 is space, 1..26 are a..z) in one single-port-write,
// registered-read memory and grows a name by weighted random choice. After
// reset the block sweeps all ALPHABET^3 entries (19683 at the default size)
// to zero, one entry per cycle, and keeps req_stall high meanwhile. One
// request is worked at a time; req_stall stays high until its response
// has been placed in the output register, and a new request may be taken
// while that response still waits. The memory read port and one shared
// adder/comparator set the pace: a write passes through the write and done
// states, while a start request, or a next-symbol request below the length
// cap, first totals its row (the whole space row of ALPHABET^2 entries for
// a start, ALPHABET entries for a next symbol), then scales the threshold
// and then rescans the row.
// The threshold is built by RAND_WIDTH shift-add steps on the same adder.

module trigram_weighted_char_sampler #(
   parameter int ALPHABET   = 27,
   parameter int MAX_LEN    = 64,
   parameter int FREQ_WIDTH = 16,
   parameter int RAND_WIDTH = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire tws_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output tws_pkg::rsp_type     rsp_payload
);

   localparam int DEPTH = ALPHABET * ALPHABET * ALPHABET;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = $clog2(ALPHABET);
   localparam int CW    = $clog2(ALPHABET * ALPHABET + 1);
   localparam int XW    = FREQ_WIDTH + $clog2(ALPHABET * ALPHABET) + 1;
   localparam int STW   = $clog2(RAND_WIDTH);
   localparam int SYM_W = tws_pkg::SYM_W;
   localparam int LEN_W = tws_pkg::LEN_W;

   localparam logic [AW-1:0]    A_AW       = AW'(ALPHABET);
   localparam logic [AW-1:0]    LAST_ADDR  = AW'(DEPTH - 1);
   localparam logic [CW-1:0]    ROW_COUNT  = CW'(ALPHABET);
   localparam logic [CW-1:0]    SPACE_CNT  = CW'(ALPHABET * ALPHABET);
   localparam logic [SW-1:0]    SYM_LAST   = SW'(ALPHABET - 1);
   localparam logic [STW-1:0]   STEP_LAST  = STW'(RAND_WIDTH - 1);
   localparam logic [LEN_W-1:0] LEN_LIMIT  = LEN_W'(MAX_LEN);
   localparam logic [LEN_W-1:0] ALPHA_LEN  = LEN_W'(ALPHABET);

   tws_pkg::state_type state_ff, state_in;
   tws_pkg::req_type   req_ff, req_in;
   tws_pkg::rsp_type   res_ff, res_in;
   tws_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0]         addr_ff, addr_in;
   logic [AW-1:0]         base_ff, base_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         limit_ff, limit_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [XW-1:0]         total_ff, total_in;
   logic [XW-1:0]         thr_ff, thr_in;
   logic [XW-1:0]         run_ff, run_in;
   logic [RAND_WIDTH-1:0] frac_ff, frac_in;
   logic [STW-1:0]        step_ff, step_in;
   logic [SW-1:0]         i_ff, i_in;
   logic [SW-1:0]         j_ff, j_in;
   logic [SYM_W-1:0]      prev_ff, prev_in;
   logic [SYM_W-1:0]      last_ff, last_in;
   logic [LEN_W-1:0]      len_ff, len_in;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [FREQ_WIDTH-1:0] mem_wdata;
   logic [FREQ_WIDTH-1:0] mem_rdata;

   logic [XW-1:0] alu_a, alu_b, alu_sum;
   logic          alu_gt;

   logic          keys_ok;
   logic          pair_ok;
   logic [AW-1:0] key_addr;
   logic [AW-1:0] row_addr;

   tws_mem #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .FW    (FREQ_WIDTH)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (addr_ff),
      .rdata (mem_rdata)
   );

   tws_alu #(
      .W (XW)
   ) u_alu (
      .op_a    (alu_a),
      .op_b    (alu_b),
      .cmp_ref (thr_ff),
      .sum     (alu_sum),
      .gt      (alu_gt)
   );

   // Table addressing: index = (first * ALPHABET + second) * ALPHABET + third.
   assign keys_ok = ({2'b00, req_ff.key_first}  < ALPHA_LEN) &&
                    ({2'b00, req_ff.key_second} < ALPHA_LEN) &&
                    ({2'b00, req_ff.key_third}  < ALPHA_LEN);
   assign key_addr = (AW'(req_ff.key_first) * A_AW + AW'(req_ff.key_second)) * A_AW
                     + AW'(req_ff.key_third);
   assign pair_ok  = ({2'b00, prev_ff} < ALPHA_LEN) && ({2'b00, last_ff} < ALPHA_LEN);
   assign row_addr = (AW'(prev_ff) * A_AW + AW'(last_ff)) * A_AW;

   // Route the shared adder: total while summing, threshold while scaling,
   // running sum while scanning.
   always_comb begin
      alu_a = run_ff;
      alu_b = XW'(mem_rdata);
      unique case (state_ff)
         tws_pkg::ST_SUM: begin
            alu_a = total_ff;
         end
         tws_pkg::ST_SCALE: begin
            alu_a = thr_ff;
            alu_b = frac_ff[0] ? total_ff : '0;
         end
         default: begin
            alu_a = run_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tws_pkg::ST_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         prev_ff      <= '0;
         last_ff      <= '0;
         len_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         prev_ff      <= prev_in;
         last_ff      <= last_in;
         len_ff       <= len_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
      base_ff  <= base_in;
      cnt_ff   <= cnt_in;
      limit_ff <= limit_in;
      total_ff <= total_in;
      thr_ff   <= thr_in;
      run_ff   <= run_in;
      frac_ff  <= frac_in;
      step_ff  <= step_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      addr_in      = addr_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      limit_in     = limit_ff;
      rd_vld_in    = 1'b0;
      total_in     = total_ff;
      thr_in       = thr_ff;
      run_in       = run_ff;
      frac_in      = frac_ff;
      step_in      = step_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      prev_in      = prev_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = '0;
      req_stall    = (state_ff != tws_pkg::ST_IDLE);

      unique case (state_ff)
         // Zero the table one entry per cycle after reset.
         tws_pkg::ST_CLEAR: begin
            mem_we  = 1'b1;
            addr_in = addr_ff + AW'(1);
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = tws_pkg::ST_IDLE;
            end
         end

         tws_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               frac_in  = RAND_WIDTH'(req_payload.random_fraction);
               cnt_in   = '0;
               total_in = '0;
               unique case (req_payload.func)
                  tws_pkg::FUNC_WRITE: begin
                     state_in = tws_pkg::ST_WRITE;
                  end
                  tws_pkg::FUNC_START: begin
                     // space row is the first ALPHABET^2 entries
                     addr_in  = '0;
                     base_in  = '0;
                     limit_in = SPACE_CNT;
                     state_in = tws_pkg::ST_SUM;
                  end
                  tws_pkg::FUNC_NEXT: begin
                     if (len_ff >= LEN_LIMIT) begin
                        res_in   = '{symbol_a: '0, symbol_b: '0,
                                     status: tws_pkg::STATUS_OVERFLOW};
                        state_in = tws_pkg::ST_DONE;
                     end else if (!pair_ok) begin
                        res_in   = '{symbol_a: '0, symbol_b: '0,
                                     status: tws_pkg::STATUS_EMPTY};
                        state_in = tws_pkg::ST_DONE;
                     end else begin
                        addr_in  = row_addr;
                        base_in  = row_addr;
                        limit_in = ROW_COUNT;
                        state_in = tws_pkg::ST_SUM;
                     end
                  end
                  default: begin
                     // drop unknown functions without a response
                     state_in = tws_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         tws_pkg::ST_WRITE: begin
            mem_we    = keys_ok;
            mem_waddr = key_addr;
            mem_wdata = FREQ_WIDTH'(req_ff.frequency);
            res_in    = '{symbol_a: '0, symbol_b: '0, status: tws_pkg::STATUS_WRITTEN};
            state_in  = tws_pkg::ST_DONE;
         end

         // Stream the row through the read port and total it.
         tws_pkg::ST_SUM: begin
            if (cnt_ff != limit_ff) begin
               addr_in   = addr_ff + AW'(1);
               cnt_in    = cnt_ff + CW'(1);
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               total_in = alu_sum;
            end
            if (rd_vld_ff && (cnt_ff == limit_ff)) begin
               thr_in   = '0;
               step_in  = '0;
               state_in = tws_pkg::ST_SCALE;
            end
         end

         // threshold = (total * fraction) >> RAND_WIDTH, LSB first,
         // halving after each add so only the integer part is kept
         tws_pkg::ST_SCALE: begin
            if (total_ff == '0) begin
               res_in   = '{symbol_a: '0, symbol_b: '0, status: tws_pkg::STATUS_EMPTY};
               state_in = tws_pkg::ST_DONE;
            end else begin
               thr_in  = alu_sum >> 1;
               frac_in = frac_ff >> 1;
               step_in = step_ff + STW'(1);
               if (step_ff == STEP_LAST) begin
                  addr_in  = base_ff;
                  cnt_in   = '0;
                  run_in   = '0;
                  i_in     = '0;
                  j_in     = '0;
                  state_in = tws_pkg::ST_SCAN;
               end
            end
         end

         // Rescan the row; first entry whose running sum passes the
         // threshold is the pick. i/j track the entry whose data is here.
         tws_pkg::ST_SCAN: begin
            if (cnt_ff != limit_ff) begin
               addr_in   = addr_ff + AW'(1);
               cnt_in    = cnt_ff + CW'(1);
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               run_in = alu_sum;
               if (j_ff == SYM_LAST) begin
                  j_in = '0;
                  i_in = i_ff + SW'(1);
               end else begin
                  j_in = j_ff + SW'(1);
               end
               if (alu_gt) begin
                  state_in = tws_pkg::ST_DONE;
                  if (req_ff.func == tws_pkg::FUNC_START) begin
                     prev_in = SYM_W'(i_ff);
                     last_in = SYM_W'(j_ff);
                     len_in  = LEN_W'(2);
                     res_in  = '{symbol_a: SYM_W'(i_ff), symbol_b: SYM_W'(j_ff),
                                 status: tws_pkg::STATUS_ADDED};
                  end else if (j_ff == '0) begin
                     // space ends the name, keep the stored pair
                     res_in = '{symbol_a: '0, symbol_b: '0,
                                status: tws_pkg::STATUS_COMPLETE};
                  end else begin
                     prev_in = last_ff;
                     last_in = SYM_W'(j_ff);
                     len_in  = len_ff + LEN_W'(1);
                     res_in  = '{symbol_a: SYM_W'(j_ff), symbol_b: '0,
                                 status: tws_pkg::STATUS_ADDED};
                  end
               end else if (cnt_ff == limit_ff) begin
                  // never reached: threshold stays below a nonzero total
                  res_in   = '{symbol_a: '0, symbol_b: '0, status: tws_pkg::STATUS_EMPTY};
                  state_in = tws_pkg::ST_DONE;
               end
            end
         end

         // Hold the response until the output register is free.
         tws_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = tws_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tws_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

### tb/trigram_weighted_char_sampler_test.sv
`default_nettype none

module trigram_weighted_char_sampler_test;

   localparam int ALPHA         = 27;
   localparam int TABLE_ENTRIES = ALPHA * ALPHA * ALPHA;
   localparam int MAX_NAME      = 64;
   localparam int RAND_BITS     = 16;
   localparam int ITEM_GOAL     = 1600;
   localparam int SYM_W         = tws_pkg::SYM_W;
   localparam int LEN_W         = tws_pkg::LEN_W;
   localparam int FUNC_W        = tws_pkg::FUNC_W;
   localparam int FIELD_W       = tws_pkg::FIELD_W;
   // The clearing sweep after reset is the longest quiet stretch.
   localparam int IDLE_LIMIT    = 100000;
   // A start request walks the space row twice.
   localparam int SETTLE_CYCLES = 2000;

   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
   localparam logic [SYM_W-1:0]  SPACE     = 5'd0;
   localparam logic [SYM_W-1:0]  SYM_END   = 5'd27;

   typedef struct packed {
      tws_pkg::req_type req;
      logic             drain;   // hold this request until every response is back
   } pending_request_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   tws_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   tws_pkg::rsp_type rsp_payload;

   trigram_weighted_char_sampler dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the sampler: frequency table, current pair and name length.
   // ---------------------------------------------------------------------
   bit [FIELD_W-1:0] freq_model [TABLE_ENTRIES];
   logic [SYM_W-1:0] word_prev = '0;
   logic [SYM_W-1:0] word_last = '0;
   logic [LEN_W-1:0] word_len  = '0;

   pending_request_type    pending_requests[$];
   tws_pkg::rsp_type       expected_picks[$];
   logic [3*SYM_W-1:0]     touched_keys[$];
   logic                   drain_next     = 1'b0;
   int                     items_queued   = 0;
   int                     picks_predicted = 0;
   int                     reqs_taken     = 0;
   int                     rsps_taken     = 0;
   int                     n_mismatch     = 0;
   int                     idle_cycles    = 0;
   int                     func_taken [4] = '{default: 0};
   int                     status_seen [8] = '{default: 0};
   logic                   steady         = 1'b0;

   function automatic int entry_index(input int a, input int b, input int c);
      return (a * ALPHA + b) * ALPHA + c;
   endfunction

   // Work out the response that one request causes and advance the shadow state.
   function automatic void predict_pick(input tws_pkg::req_type rq, output bit has_pick,
                                        output tws_pkg::rsp_type pick);
      longint unsigned total, run, thr;
      int a, b, c, k, base, hit;
      has_pick = 1'b1;
      pick     = '{symbol_a: '0, symbol_b: '0, status: tws_pkg::STATUS_WRITTEN};
      total    = 0;
      run      = 0;
      hit      = -1;
      case (rq.func)
         tws_pkg::FUNC_WRITE: begin
            // Out-of-range keys leave the table alone but still acknowledge.
            if (rq.key_first < SYM_END && rq.key_second < SYM_END &&
                rq.key_third < SYM_END) begin
               a = int'(rq.key_first);
               b = int'(rq.key_second);
               c = int'(rq.key_third);
               freq_model[entry_index(a, b, c)] = rq.frequency;
            end
         end
         tws_pkg::FUNC_START: begin
            // The space row is the first ALPHA*ALPHA entries, row-major by pair.
            for (k = 0; k < ALPHA * ALPHA; k++) total += 64'(freq_model[k]);
            if (total == 0) begin
               pick.status = tws_pkg::STATUS_EMPTY;
            end else begin
               thr = (total * 64'(rq.random_fraction)) >> RAND_BITS;
               for (k = 0; k < ALPHA * ALPHA && hit < 0; k++) begin
                  run += 64'(freq_model[k]);
                  if (run > thr) hit = k;
               end
               pick.symbol_a = SYM_W'(hit / ALPHA);
               pick.symbol_b = SYM_W'(hit % ALPHA);
               pick.status   = tws_pkg::STATUS_ADDED;
               word_prev     = pick.symbol_a;
               word_last     = pick.symbol_b;
               word_len      = LEN_W'(2);
            end
         end
         tws_pkg::FUNC_NEXT: begin
            if (word_len >= LEN_W'(MAX_NAME)) begin
               pick.status = tws_pkg::STATUS_OVERFLOW;
            end else begin
               base = entry_index(int'(word_prev), int'(word_last), 0);
               for (k = 0; k < ALPHA; k++) total += 64'(freq_model[base + k]);
               if (total == 0) begin
                  pick.status = tws_pkg::STATUS_EMPTY;
               end else begin
                  thr = (total * 64'(rq.random_fraction)) >> RAND_BITS;
                  for (k = 0; k < ALPHA && hit < 0; k++) begin
                     run += 64'(freq_model[base + k]);
                     if (run > thr) hit = k;
                  end
                  if (hit == 0) begin
                     // Space ends the name; the pair and length stay put.
                     pick.status = tws_pkg::STATUS_COMPLETE;
                  end else begin
                     pick.symbol_a = SYM_W'(hit);
                     pick.status   = tws_pkg::STATUS_ADDED;
                     word_prev     = word_last;
                     word_last     = SYM_W'(hit);
                     word_len      = word_len + LEN_W'(1);
                  end
               end
            end
         end
         default: has_pick = 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request builders: fill the pending queue that the driver drains.
   // ---------------------------------------------------------------------
   function automatic logic [SYM_W-1:0] rand_sym();
      return SYM_W'($urandom_range(31));
   endfunction

   function automatic logic [FIELD_W-1:0] rand_field();
      return FIELD_W'($urandom);
   endfunction

   function automatic logic [FIELD_W-1:0] pick_fraction();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return rand_field();
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] pick_frequency();
      case ($urandom_range(9))
         0:         return '0;
         1:         return '1;
         2, 3, 4:   return FIELD_W'($urandom_range(15, 1));
         default:   return rand_field();
      endcase
   endfunction

   task automatic queue_request(input logic [FUNC_W-1:0] fn,
                                input logic [SYM_W-1:0] k1,
                                input logic [SYM_W-1:0] k2,
                                input logic [SYM_W-1:0] k3,
                                input logic [FIELD_W-1:0] freq,
                                input logic [FIELD_W-1:0] frac);
      pending_request_type item;
      item.req   = '{func: fn, key_first: k1, key_second: k2, key_third: k3,
                     frequency: freq, random_fraction: frac};
      item.drain = drain_next;
      drain_next = 1'b0;
      pending_requests.push_back(item);
      if (fn != FUNC_NONE) items_queued++;
      // Remember every live entry so it can be wiped before the next table.
      if (fn == tws_pkg::FUNC_WRITE && freq != '0 &&
          k1 < SYM_END && k2 < SYM_END && k3 < SYM_END)
         touched_keys.push_back({k1, k2, k3});
   endtask

   task automatic queue_write(input logic [SYM_W-1:0] k1, input logic [SYM_W-1:0] k2,
                              input logic [SYM_W-1:0] k3, input logic [FIELD_W-1:0] freq);
      queue_request(tws_pkg::FUNC_WRITE, k1, k2, k3, freq, rand_field());
   endtask

   task automatic queue_start(input logic [FIELD_W-1:0] frac);
      queue_request(tws_pkg::FUNC_START, rand_sym(), rand_sym(), rand_sym(),
                    rand_field(), frac);
   endtask

   task automatic queue_next(input logic [FIELD_W-1:0] frac);
      queue_request(tws_pkg::FUNC_NEXT, rand_sym(), rand_sym(), rand_sym(),
                    rand_field(), frac);
   endtask

   task automatic erase_touched();
      logic [3*SYM_W-1:0] key;
      while (touched_keys.size() != 0) begin
         key = touched_keys.pop_front();
         queue_write(key[3*SYM_W-1:2*SYM_W], key[2*SYM_W-1:SYM_W], key[SYM_W-1:0], '0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus, then the wait for the last response and the verdict.
   // ---------------------------------------------------------------------
   initial begin
      logic [SYM_W-1:0] letters[$];
      logic [SYM_W-1:0] letter;
      logic [SYM_W-1:0] head;
      int               epoch;
      epoch = 0;

      // Next before any start and start on an empty table: both report an empty row.
      queue_next(rand_field());
      queue_start('0);
      // Keys past 'z' are ignored but acknowledged.
      queue_write(5'd31, 5'd27, 5'd31, '1);
      queue_write(5'd26, 5'd26, 5'd27, '0);
      queue_write(SPACE, 5'd3, 5'd5, 16'd1);
      queue_write(SPACE, 5'd26, 5'd26, '1);
      queue_start('0);                  // lowest threshold picks the first live pair
      queue_start('1);                  // highest threshold picks the last live pair
      queue_next(rand_field());         // row for (z, z) is still empty
      queue_write(5'd26, 5'd26, SPACE, 16'd5);
      queue_next(rand_field());         // only space can follow: name complete
      queue_write(5'd26, 5'd26, 5'd26, '1);
      queue_next('1);                   // top of the range lands on 'z'
      queue_request(FUNC_NONE, rand_sym(), rand_sym(), rand_sym(), rand_field(), rand_field());
      queue_next('0);                   // bottom of the range lands on space
      queue_write(SPACE, 5'd3, 5'd5, '0);
      queue_start('0);
      queue_next(rand_field());
      erase_touched();

      while (items_queued < ITEM_GOAL) begin
         // Every fourth table waits for the block to drain first.
         drain_next = (epoch % 4 == 0);
         if (epoch % 7 == 3) begin
            // A lone self-looping pair keeps the name growing up to the length cap.
            letter = SYM_W'($urandom_range(26, 1));
            queue_write(SPACE, letter, letter, FIELD_W'($urandom_range(65535, 1)));
            queue_write(letter, letter, letter, FIELD_W'($urandom_range(65535, 1)));
            queue_start(pick_fraction());
            repeat (MAX_NAME) queue_next(pick_fraction());
            queue_start(pick_fraction());
            queue_next(pick_fraction());
         end else begin
            // Small random alphabet, always with space, so names both grow and end.
            letters.delete();
            letters.push_back(SPACE);
            repeat ($urandom_range(4, 1)) letters.push_back(SYM_W'($urandom_range(26, 1)));
            repeat ($urandom_range(24, 6)) begin
               head = $urandom_range(1) ? SPACE : letters[$urandom_range(letters.size() - 1)];
               queue_write(head, letters[$urandom_range(letters.size() - 1)],
                           letters[$urandom_range(letters.size() - 1)], pick_frequency());
            end
            repeat ($urandom_range(5, 2)) begin
               case ($urandom_range(9))
                  0: queue_request(FUNC_NONE, rand_sym(), rand_sym(), rand_sym(),
                                   rand_field(), rand_field());
                  1: queue_write(rand_sym(), rand_sym(), rand_sym(), pick_frequency());
                  default: ;
               endcase
               // Now and then drop the start and keep growing the old pair.
               if ($urandom_range(7) != 0) queue_start(pick_fraction());
               repeat ($urandom_range(16, 1)) queue_next(pick_fraction());
            end
         end
         erase_touched();
         epoch++;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0) @(posedge clock);
      while (expected_picks.size() != 0) @(posedge clock);
      // Hold a while longer to catch any stray response.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Requests taken: %0d writes, %0d starts, %0d next-symbol, %0d ignored codes.",
               func_taken[tws_pkg::FUNC_WRITE], func_taken[tws_pkg::FUNC_START],
               func_taken[tws_pkg::FUNC_NEXT], func_taken[FUNC_NONE]);
      $display({"Responses checked: %0d added, %0d complete, %0d overflow, ",
                "%0d empty, %0d written."},
               status_seen[tws_pkg::STATUS_ADDED], status_seen[tws_pkg::STATUS_COMPLETE],
               status_seen[tws_pkg::STATUS_OVERFLOW], status_seen[tws_pkg::STATUS_EMPTY],
               status_seen[tws_pkg::STATUS_WRITTEN]);
      if (n_mismatch == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d response mismatches", n_mismatch);
         $display("== FAIL ==");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Driver: present pending requests, predict each one as it is taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      bit               took;
      bit               gap;
      bit               present;
      bit               has_pick;
      tws_pkg::rsp_type pick;
      int               results_due;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            predict_pick(req_payload, has_pick, pick);
            if (has_pick) begin
               expected_picks.push_back(pick);
               picks_predicted++;
            end
            func_taken[req_payload.func]++;
            pending_requests.delete(0);
            reqs_taken++;
         end
         // Open a stretch with no idling on either side partway through.
         steady <= (reqs_taken >= 600 && reqs_taken < 900);
         if (!req_valid || took) begin
            // Count responses not yet taken, from values sampled before this edge.
            results_due = picks_predicted - rsps_taken -
                          ((rsp_valid === 1'b1 && !rsp_stall) ? 1 : 0);
            gap     = !steady && ($urandom_range(99) < 31);
            present = pending_requests.size() != 0 && !gap &&
                      !(pending_requests[0].drain && results_due != 0);
            req_valid <= present;
            if (present) req_payload <= pending_requests[0].req;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: take responses and compare with the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      tws_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            rsps_taken <= rsps_taken + 1;
            status_seen[rsp_payload.status]++;
            if (expected_picks.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("unexpected response: a=%0d b=%0d status=%0d", rsp_payload.symbol_a,
                           rsp_payload.symbol_b, rsp_payload.status);
            end else begin
               want = expected_picks.pop_front();
               if (rsp_payload.symbol_a !== want.symbol_a ||
                   rsp_payload.symbol_b !== want.symbol_b ||
                   rsp_payload.status   !== want.status) begin
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display({"response %0d: expected a=%0d b=%0d status=%0d, ",
                               "got a=%0d b=%0d status=%0d"},
                              rsps_taken, want.symbol_a, want.symbol_b, want.status,
                              rsp_payload.symbol_a, rsp_payload.symbol_b, rsp_payload.status);
               end
            end
         end
         rsp_stall <= !steady && ($urandom_range(99) < 31);
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: end the run when nothing moves for too long.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_progress
      if (reset || (req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("no handshake for %0d cycles, %0d requests pending, %0d responses due",
                  idle_cycles, pending_requests.size(), expected_picks.size());
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

`default_nettype wire

### files.f
rtl/tws_pkg.sv
rtl/tws_mem.sv
rtl/tws_alu.sv
rtl/trigram_weighted_char_sampler.sv
tb/trigram_weighted_char_sampler_test.sv
